[design/sdbt_pkg.sv]
// sdbt_pkg: types, codes and geometry helpers for the sparse disk block translation core
// no dependencies; imported by sdbt_front, sdbt_back and the top level
`default_nettype none

package sdbt_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int IDX_W           = 16;

    localparam logic [31:0] UNALLOC    = 32'hFFFF_FFFF;
    localparam logic [33:0] FREE_LIMIT = 34'h0_FFFF_FFFF;
    localparam logic [4:0]  MIN_LOG2   = 5'd9;
    localparam logic [4:0]  BITMAP_LOG2 = 5'd21;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    localparam logic [2:0] ST_MAPPED    = 3'd0;
    localparam logic [2:0] ST_UNALLOC   = 3'd1;
    localparam logic [2:0] ST_ALLOCATED = 3'd2;
    localparam logic [2:0] ST_REFUSED   = 3'd3;
    localparam logic [2:0] ST_LOADED    = 3'd4;

    localparam logic [1:0] REG_BLOCK_LOG2   = 2'd0;
    localparam logic [1:0] REG_TABLE_ENTRIES = 2'd1;
    localparam logic [1:0] REG_DISK_SECTORS = 2'd2;
    localparam logic [1:0] REG_FREE_START   = 2'd3;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_READ,
        OP_WRITE
    } t_op;

    typedef enum logic {
        BK_IDLE,
        BK_EXEC
    } t_back_state;

    typedef struct packed {
        t_op              op;
        logic             in_range;
        logic             beyond_disk;
        logic [IDX_W-1:0] idx;
        logic [9:0]       upd_idx;
        logic [22:0]      off;
        logic [31:0]      word;
    } t_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [33:0] file_sector;
        logic        bitmap_fill;
        logic [31:0] bitmap_sector;
        logic        table_update;
        logic [9:0]  update_index;
        logic [33:0] footer_sector;
    } t_result;

    function automatic logic [4:0] f_eff_log2(input logic [4:0] l);
        return (l < MIN_LOG2) ? MIN_LOG2 : l;
    endfunction

    function automatic logic [22:0] f_block_sectors(input logic [4:0] l);
        logic [4:0] e;
        e = f_eff_log2(l) - MIN_LOG2;
        return 23'(1) << e;
    endfunction

    function automatic logic [10:0] f_bitmap_sectors(input logic [4:0] l);
        logic [4:0] e;
        e = f_eff_log2(l);
        return (e <= BITMAP_LOG2) ? 11'd1 : (11'd1 << (e - BITMAP_LOG2));
    endfunction

endpackage

`default_nettype wire

[design/sdbt_ram.sv]
// sdbt_ram: generic single-write, single-read RAM with registered read data
// no dependencies
`default_nettype none

module sdbt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                        i_wdata,
    input  wire logic                                    i_re,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[design/sdbt_front.sv]
// sdbt_front: accepts input words, decodes kind and block geometry, two-entry queue
// depends on sdbt_pkg
`default_nettype none

module sdbt_front
    import sdbt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [4:0]  i_block_log2,
    input  wire logic [10:0] i_table_entries,
    input  wire logic [31:0] i_disk_sectors,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_kind,
    input  wire logic [31:0] i_sector,
    input  wire logic [9:0]  i_load_index,
    input  wire logic [31:0] i_load_word,
    output t_item            o_head,
    output logic             o_head_valid,
    input  wire logic        i_pop
);

    localparam logic [16:0] DEPTH_V = 17'(TABLE_DEPTH);

    logic [4:0]  shift;
    logic [31:0] bidx;
    logic [31:0] blk_off;
    logic [16:0] eff_entries;
    logic        push;
    t_item       n_item;

    t_item       r_q [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;
    logic [1:0]  n_cnt;

    always_comb begin
        shift       = f_eff_log2(i_block_log2) - MIN_LOG2;
        bidx        = i_sector >> shift;
        blk_off     = i_sector & ~(32'hFFFF_FFFF << shift);
        eff_entries = ({6'd0, i_table_entries} > DEPTH_V) ? DEPTH_V
                                                           : {6'd0, i_table_entries};
        n_item.beyond_disk = i_sector >= i_disk_sectors;
        n_item.upd_idx     = bidx[9:0];
        n_item.off         = 23'(blk_off[21:0]) + 23'(f_bitmap_sectors(i_block_log2));
        n_item.word        = i_load_word;
        case (i_kind)
            KIND_LOAD: begin
                n_item.op       = OP_LOAD;
                n_item.idx      = IDX_W'(i_load_index);
                n_item.in_range = {7'd0, i_load_index} < DEPTH_V;
            end
            KIND_WRITE: begin
                n_item.op       = OP_WRITE;
                n_item.idx      = bidx[IDX_W-1:0];
                n_item.in_range = bidx < {15'd0, eff_entries};
            end
            default: begin
                n_item.op       = OP_READ;
                n_item.idx      = bidx[IDX_W-1:0];
                n_item.in_range = bidx < {15'd0, eff_entries};
            end
        endcase
    end

    assign o_ready      = r_cnt != 2'd2;
    assign push         = i_valid && o_ready;
    assign o_head       = r_q[r_rp];
    assign o_head_valid = r_cnt != 2'd0;
    assign n_cnt        = r_cnt + {1'b0, push} - {1'b0, i_pop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_item;
        end
    end

endmodule

`default_nettype wire

[design/sdbt_back.sv]
// sdbt_back: table lookup, allocation and write-back, result register
// depends on sdbt_pkg and sdbt_ram
`default_nettype none

module sdbt_back
    import sdbt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [4:0]  i_block_log2,
    input  wire logic        i_free_load,
    input  wire logic [33:0] i_free_value,
    input  wire t_item       i_head,
    input  wire logic        i_head_valid,
    output logic             o_pop,
    output logic             o_valid,
    input  wire logic        i_ready,
    output t_result          o_result
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    t_back_state r_state, n_state;
    t_item       r_cur;
    logic [33:0] r_free, n_free;
    logic [31:0] r_lbb, n_lbb;
    logic        r_lbv, n_lbv;
    logic        r_out_valid, n_out_valid;
    t_result     r_out, n_out;

    logic        we;
    logic [31:0] wdata;
    logic [31:0] rdata;
    logic [33:0] step;
    logic [31:0] entry;
    logic [33:0] load_next;
    logic [33:0] alloc_next;

    sdbt_ram #(
        .WIDTH (32),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_cur.idx[AW-1:0]),
        .i_wdata (wdata),
        .i_re    (o_pop),
        .i_raddr (i_head.idx[AW-1:0]),
        .o_rdata (rdata)
    );

    assign step       = 34'(f_block_sectors(i_block_log2)) + 34'(f_bitmap_sectors(i_block_log2));
    assign entry      = r_cur.in_range ? rdata : UNALLOC;
    assign load_next  = {2'd0, r_cur.word} + step;
    assign alloc_next = r_free + step;

    always_comb begin
        case (r_state)
            BK_IDLE: n_state = o_pop ? BK_EXEC : BK_IDLE;
            BK_EXEC: n_state = BK_IDLE;
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop       = (r_state == BK_IDLE) && i_head_valid && (!r_out_valid || i_ready);
        we          = 1'b0;
        wdata       = r_cur.word;
        n_free      = r_free;
        n_lbb       = r_lbb;
        n_lbv       = r_lbv;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;
        if (r_state == BK_EXEC) begin
            n_out_valid = 1'b1;
            n_out       = '0;
            if (r_cur.op == OP_LOAD) begin
                n_out.status = ST_LOADED;
                if (r_cur.in_range) begin
                    we = 1'b1;
                    if (r_cur.word != UNALLOC && load_next > r_free) begin
                        n_free = load_next;
                    end
                end
            end else if (entry != UNALLOC) begin
                n_out.status      = ST_MAPPED;
                n_out.file_sector = {2'd0, entry} + 34'(r_cur.off);
                if (r_cur.op == OP_WRITE && (!r_lbv || r_lbb != entry)) begin
                    n_lbb               = entry;
                    n_lbv               = 1'b1;
                    n_out.bitmap_fill   = 1'b1;
                    n_out.bitmap_sector = entry;
                end
            end else if (r_cur.op != OP_WRITE) begin
                n_out.status = ST_UNALLOC;
            end else if (!r_cur.in_range || r_cur.beyond_disk || r_free >= FREE_LIMIT) begin
                n_out.status = ST_REFUSED;
            end else begin
                we                  = 1'b1;
                wdata               = r_free[31:0];
                n_free              = alloc_next;
                n_out.status        = ST_ALLOCATED;
                n_out.file_sector   = {2'd0, r_free[31:0]} + 34'(r_cur.off);
                n_out.bitmap_fill   = 1'b1;
                n_out.bitmap_sector = r_free[31:0];
                n_out.table_update  = 1'b1;
                n_out.update_index  = r_cur.upd_idx;
                n_out.footer_sector = alloc_next;
            end
        end
        if (i_free_load) begin
            n_free = i_free_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_free      <= '0;
            r_lbb       <= '0;
            r_lbv       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_free      <= n_free;
            r_lbb       <= n_lbb;
            r_lbv       <= n_lbv;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_head;
        end
        r_out <= n_out;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

`default_nettype wire

[design/sparse_disk_block_translation_core.sv]
// sparse_disk_block_translation_core: guest sector to image sector translation top level
// a word passes the queue, the registered table read and the result register
// no new word is taken until the last one is done and no result is waiting
// a two-entry queue decouples input acceptance from the lookup engine
// reset: synchronous active low; clears queue, engine state, free pointer and registers
// the allocation table is not cleared and holds undefined data until loaded
`default_nettype none

module sparse_disk_block_translation_core
    import sdbt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_kind,
    input  wire logic [31:0] i_sector,
    input  wire logic [9:0]  i_load_index,
    input  wire logic [31:0] i_load_word,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_status,
    output logic [33:0]      o_file_sector,
    output logic             o_bitmap_fill,
    output logic [31:0]      o_bitmap_sector,
    output logic             o_table_update,
    output logic [9:0]       o_update_index,
    output logic [33:0]      o_footer_sector
);

    logic [4:0]  r_block_log2;
    logic [10:0] r_table_entries;
    logic [31:0] r_disk_sectors;
    logic [33:0] r_free_start;
    logic        cfg_wr;
    logic        free_load;
    t_item       head;
    logic        head_valid;
    logic        pop;
    t_result     result;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign free_load = cfg_wr && (paddr[4:3] == REG_FREE_START);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_log2    <= 5'd21;
            r_table_entries <= '0;
            r_disk_sectors  <= '0;
            r_free_start    <= '0;
        end else if (cfg_wr) begin
            case (paddr[4:3])
                REG_BLOCK_LOG2:    r_block_log2    <= pwdata[4:0];
                REG_TABLE_ENTRIES: r_table_entries <= pwdata[10:0];
                REG_DISK_SECTORS:  r_disk_sectors  <= pwdata[31:0];
                REG_FREE_START:    r_free_start    <= pwdata[33:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:3])
            REG_BLOCK_LOG2:    prdata = 64'(r_block_log2);
            REG_TABLE_ENTRIES: prdata = 64'(r_table_entries);
            REG_DISK_SECTORS:  prdata = 64'(r_disk_sectors);
            REG_FREE_START:    prdata = 64'(r_free_start);
            default:           prdata = '0;
        endcase
    end

    sdbt_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_block_log2    (r_block_log2),
        .i_table_entries (r_table_entries),
        .i_disk_sectors  (r_disk_sectors),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_kind          (i_kind),
        .i_sector        (i_sector),
        .i_load_index    (i_load_index),
        .i_load_word     (i_load_word),
        .o_head          (head),
        .o_head_valid    (head_valid),
        .i_pop           (pop)
    );

    sdbt_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_block_log2 (r_block_log2),
        .i_free_load  (free_load),
        .i_free_value (pwdata[33:0]),
        .i_head       (head),
        .i_head_valid (head_valid),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_result     (result)
    );

    assign o_status        = result.status;
    assign o_file_sector   = result.file_sector;
    assign o_bitmap_fill   = result.bitmap_fill;
    assign o_bitmap_sector = result.bitmap_sector;
    assign o_table_update  = result.table_update;
    assign o_update_index  = result.update_index;
    assign o_footer_sector = result.footer_sector;

    a_pop_nonempty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> head_valid)
        else $error("queue popped while empty");

    a_pop_spacing : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> !pop)
        else $error("engine took two words in consecutive cycles");

    a_update_alloc : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_table_update) |-> (o_status == ST_ALLOCATED && o_bitmap_fill))
        else $error("table update without allocation");

    a_refused_clean : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_REFUSED || o_status == ST_UNALLOC))
            |-> (o_file_sector == '0 && !o_bitmap_fill))
        else $error("unmapped result carries a sector");

endmodule

`default_nettype wire

[sim/tb_sparse_disk_block_translation_core.sv]
// tb_sparse_disk_block_translation_core: self-checking bench for the sector translation core
// predicts every result word from its own copy of the allocation table and registers
// depends on sdbt_pkg and sparse_disk_block_translation_core
`default_nettype none

module tb_sparse_disk_block_translation_core;
    import sdbt_pkg::*;

    localparam logic [1:0]  KIND_SPARE  = 2'd3;
    localparam logic [31:0] SECTOR_MAX  = 32'd4261413375;
    localparam int          LATENCY     = 3;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          PRINT_LIMIT = 40;

    localparam int PICK_LOADED = 0;
    localparam int PICK_RECENT = 1;
    localparam int PICK_BEYOND = 2;
    localparam int PICK_RAW    = 3;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [4:0]  paddr        = '0;
    logic [63:0] pwdata       = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        i_valid      = 1'b0;
    logic        o_ready;
    logic [1:0]  i_kind       = '0;
    logic [31:0] i_sector     = '0;
    logic [9:0]  i_load_index = '0;
    logic [31:0] i_load_word  = '0;
    logic        o_valid;
    logic        i_ready      = 1'b0;
    logic [2:0]  o_status;
    logic [33:0] o_file_sector;
    logic        o_bitmap_fill;
    logic [31:0] o_bitmap_sector;
    logic        o_table_update;
    logic [9:0]  o_update_index;
    logic [33:0] o_footer_sector;

    sparse_disk_block_translation_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_kind          (i_kind),
        .i_sector        (i_sector),
        .i_load_index    (i_load_index),
        .i_load_word     (i_load_word),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_file_sector   (o_file_sector),
        .o_bitmap_fill   (o_bitmap_fill),
        .o_bitmap_sector (o_bitmap_sector),
        .o_table_update  (o_table_update),
        .o_update_index  (o_update_index),
        .o_footer_sector (o_footer_sector)
    );

    always #2 i_clk = ~i_clk;

    // shadow registers and translation state
    logic [4:0]  cfg_block_log2    = 5'd21;
    logic [10:0] cfg_table_entries = '0;
    logic [31:0] cfg_disk_sectors  = '0;
    logic [33:0] cfg_free_start    = '0;
    logic [33:0] free_ptr          = '0;
    logic [31:0] bitmap_block      = '0;
    logic        bitmap_block_valid = 1'b0;
    logic [31:0] alloc_table [TABLE_DEPTH_DEF];
    bit          entry_loaded [TABLE_DEPTH_DEF];
    int          loaded_slots [$];
    logic [31:0] last_sector = '0;

    t_result pending_translations [$];
    int      error_count = 0;
    int      cycle_count = 0;
    int      gap_pct     = 0;
    int      stall_pct   = 0;

    function automatic logic [4:0] block_shift();
        logic [4:0] l;
        l = (cfg_block_log2 < MIN_LOG2) ? MIN_LOG2 : cfg_block_log2;
        return l - MIN_LOG2;
    endfunction

    function automatic logic [10:0] active_entries();
        return (cfg_table_entries > 11'(TABLE_DEPTH_DEF)) ? 11'(TABLE_DEPTH_DEF)
                                                           : cfg_table_entries;
    endfunction

    function automatic t_result translate_word(logic [1:0] kind, logic [31:0] sector,
                                               logic [9:0] lidx, logic [31:0] lword);
        t_result     r;
        logic [4:0]  sh;
        logic [4:0]  l;
        logic [33:0] blk;
        logic [33:0] bmp;
        logic [33:0] offset;
        logic [33:0] next_free;
        logic [31:0] bidx;
        logic [31:0] entry;
        logic [31:0] base;
        logic        in_table;
        logic        is_write;
        r = '0;
        sh = block_shift();
        l = sh + MIN_LOG2;
        blk = 34'd1 << sh;
        bmp = (l <= BITMAP_LOG2) ? 34'd1 : (34'd1 << (l - BITMAP_LOG2));
        bidx = sector >> sh;
        offset = {2'b00, sector} & (blk - 34'd1);
        in_table = bidx < {21'd0, active_entries()};
        if (kind == KIND_LOAD) begin
            r.status = ST_LOADED;
            alloc_table[lidx] = lword;
            if (!entry_loaded[lidx]) begin
                entry_loaded[lidx] = 1'b1;
                loaded_slots.push_back(int'(lidx));
            end
            if (lword != UNALLOC) begin
                next_free = {2'b00, lword} + bmp + blk;
                if (next_free > free_ptr) free_ptr = next_free;
            end
        end else begin
            is_write = (kind == KIND_WRITE);
            entry = in_table ? alloc_table[bidx[9:0]] : UNALLOC;
            if (in_table && entry != UNALLOC) begin
                r.status = ST_MAPPED;
                r.file_sector = {2'b00, entry} + bmp + offset;
                if (is_write && (!bitmap_block_valid || bitmap_block != entry)) begin
                    bitmap_block = entry;
                    bitmap_block_valid = 1'b1;
                    r.bitmap_fill = 1'b1;
                    r.bitmap_sector = entry;
                end
            end else if (!is_write) begin
                r.status = ST_UNALLOC;
            end else if (!in_table || sector >= cfg_disk_sectors ||
                         free_ptr >= {2'b00, UNALLOC}) begin
                r.status = ST_REFUSED;
            end else begin
                base = free_ptr[31:0];
                alloc_table[bidx[9:0]] = base;
                free_ptr = free_ptr + bmp + blk;
                r.status = ST_ALLOCATED;
                r.file_sector = {2'b00, base} + bmp + offset;
                r.bitmap_fill = 1'b1;
                r.bitmap_sector = base;
                r.table_update = 1'b1;
                r.update_index = bidx[9:0];
                r.footer_sector = free_ptr;
            end
        end
        return r;
    endfunction

    // a lookup may only touch table entries that hold a loaded value
    function automatic bit sector_allowed(logic [31:0] s);
        logic [31:0] b;
        b = s >> block_shift();
        return (s <= SECTOR_MAX) &&
               (b >= {21'd0, active_entries()} || entry_loaded[b[9:0]]);
    endfunction

    function automatic logic [31:0] choose_sector(int mode);
        logic [31:0] s;
        logic [31:0] mask;
        logic [31:0] maxb;
        logic [31:0] b;
        logic [4:0]  sh;
        int          m;
        int          tries;
        sh = block_shift();
        mask = (32'd1 << sh) - 32'd1;
        maxb = SECTOR_MAX >> sh;
        m = mode;
        for (tries = 0; tries < 20; tries++) begin
            case (m)
                PICK_LOADED: begin
                    b = loaded_slots[$urandom_range(0, loaded_slots.size() - 1)];
                    s = (b << sh) | ($urandom & mask);
                end
                PICK_RECENT: begin
                    s = (last_sector & ~mask) | ($urandom & mask);
                end
                PICK_BEYOND: begin
                    if ({21'd0, active_entries()} <= maxb)
                        b = $urandom_range(32'(active_entries()), maxb);
                    else
                        b = 32'd0;
                    s = (b << sh) | ($urandom & mask);
                    if (s > SECTOR_MAX) s = SECTOR_MAX;
                end
                default: begin
                    s = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 4095);
                end
            endcase
            if (sector_allowed(s)) return s;
            m = PICK_RAW;
        end
        // block zero is loaded early and stays loaded
        return $urandom & mask;
    endfunction

    function automatic logic [31:0] choose_load_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) return UNALLOC;
        if (r < 72) return $urandom_range(0, 32'h0010_0000);
        if (r < 97) return $urandom;
        return 32'hFFFF_FFF0 + $urandom_range(0, 14);
    endfunction

    function automatic logic [63:0] register_value(logic [1:0] idx);
        case (idx)
            REG_BLOCK_LOG2:    return {59'd0, cfg_block_log2};
            REG_TABLE_ENTRIES: return {53'd0, cfg_table_entries};
            REG_DISK_SECTORS:  return {32'd0, cfg_disk_sectors};
            default:           return {30'd0, cfg_free_start};
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (error_count < PRINT_LIMIT)
            $display("mismatch %s: got %0h want %0h", what, got, want);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_sparse_disk_block_translation_core NOT OK");
            $finish;
        end
    end

    // result side back-pressure
    initial begin
        forever begin
            @(posedge i_clk);
            if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
            i_ready <= 1'b1;
        end
    end

    initial begin
        t_result want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                if (pending_translations.size() == 0) begin
                    report_mismatch("unexpected word status", 64'(o_status), 64'd0);
                end else begin
                    want = pending_translations.pop_front();
                    if (o_status !== want.status)
                        report_mismatch("status", 64'(o_status), 64'(want.status));
                    if (o_file_sector !== want.file_sector)
                        report_mismatch("file_sector", 64'(o_file_sector),
                                        64'(want.file_sector));
                    if (o_bitmap_fill !== want.bitmap_fill)
                        report_mismatch("bitmap_fill", 64'(o_bitmap_fill),
                                        64'(want.bitmap_fill));
                    if (o_bitmap_sector !== want.bitmap_sector)
                        report_mismatch("bitmap_sector", 64'(o_bitmap_sector),
                                        64'(want.bitmap_sector));
                    if (o_table_update !== want.table_update)
                        report_mismatch("table_update", 64'(o_table_update),
                                        64'(want.table_update));
                    if (o_update_index !== want.update_index)
                        report_mismatch("update_index", 64'(o_update_index),
                                        64'(want.update_index));
                    if (o_footer_sector !== want.footer_sector)
                        report_mismatch("footer_sector", 64'(o_footer_sector),
                                        64'(want.footer_sector));
                end
            end
        end
    end

    task automatic send_word(logic [1:0] kind, logic [31:0] sector, logic [9:0] lidx,
                             logic [31:0] lword);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_kind       <= kind;
        i_sector     <= sector;
        i_load_index <= lidx;
        i_load_word  <= lword;
        do @(posedge i_clk); while (!o_ready);
        pending_translations.push_back(translate_word(kind, sector, lidx, lword));
        if (kind != KIND_LOAD) last_sector = sector;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_translations.size() != 0);
    endtask

    task automatic settle();
        wait_drained();
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_register(logic [1:0] idx, logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_BLOCK_LOG2:    cfg_block_log2 = value[4:0];
            REG_TABLE_ENTRIES: cfg_table_entries = value[10:0];
            REG_DISK_SECTORS:  cfg_disk_sectors = value[31:0];
            default: begin
                cfg_free_start = value[33:0];
                free_ptr = value[33:0];
            end
        endcase
        @(posedge i_clk);
    endtask

    task automatic check_register(logic [1:0] idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 3'b000};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== register_value(idx))
            report_mismatch("register read", prdata, register_value(idx));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_setting(logic [4:0] l, logic [10:0] ents, logic [31:0] disk,
                                 logic [33:0] start);
        settle();
        write_register(REG_BLOCK_LOG2, {59'd0, l});
        write_register(REG_TABLE_ENTRIES, {53'd0, ents});
        write_register(REG_DISK_SECTORS, {32'd0, disk});
        write_register(REG_FREE_START, {30'd0, start});
        check_register(REG_BLOCK_LOG2);
        check_register(REG_TABLE_ENTRIES);
        check_register(REG_DISK_SECTORS);
        check_register(REG_FREE_START);
    endtask

    task automatic apply_random_setting();
        logic [4:0]  l;
        logic [10:0] ents;
        logic [31:0] disk;
        logic [33:0] start;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 20)      l = 5'd31;
        else if (r < 40) l = 5'd9;
        else if (r < 50) l = 5'($urandom_range(0, 8));
        else             l = 5'($urandom_range(9, 31));
        r = $urandom_range(0, 99);
        if (r < 10)      ents = 11'd1024;
        else if (r < 15) ents = 11'd2047;
        else if (r < 20) ents = 11'd0;
        else             ents = 11'($urandom_range(1, 1024));
        disk = ($urandom_range(0, 99) < 70) ? SECTOR_MAX : $urandom_range(0, SECTOR_MAX);
        r = $urandom_range(0, 99);
        if (r < 80)      start = 34'($urandom_range(0, 32'h0100_0000));
        else if (r < 90) start = {2'($urandom_range(0, 3)), 32'($urandom)};
        else             start = 34'h0_FFFF_FFF0 + 34'($urandom_range(0, 31));
        apply_setting(l, ents, disk, start);
    endtask

    task automatic run_random_items(int count, int drain_every);
        int          n;
        int          r;
        int          mode;
        logic [1:0]  kind;
        logic [31:0] s;
        logic [31:0] w;
        logic [9:0]  li;
        for (n = 0; n < count; n++) begin
            if (drain_every != 0 && n % drain_every == drain_every - 1) wait_drained();
            r = $urandom_range(0, 99);
            w = choose_load_word();
            s = $urandom;
            if ($urandom_range(0, 99) < 70 && active_entries() != 0)
                li = 10'($urandom_range(0, active_entries() - 1));
            else
                li = 10'($urandom_range(0, 1023));
            if (r < 22) begin
                kind = KIND_LOAD;
            end else begin
                if (r < 45)      kind = KIND_READ;
                else if (r < 95) kind = KIND_WRITE;
                else             kind = KIND_SPARE;
                r = $urandom_range(0, 99);
                if (r < 55)      mode = PICK_LOADED;
                else if (r < 70) mode = PICK_RECENT;
                else if (r < 85) mode = PICK_BEYOND;
                else             mode = PICK_RAW;
                s = choose_sector(mode);
            end
            send_word(kind, s, li, w);
        end
    endtask

    task automatic test_register_reset();
        check_register(REG_BLOCK_LOG2);
        check_register(REG_TABLE_ENTRIES);
        check_register(REG_DISK_SECTORS);
        check_register(REG_FREE_START);
    endtask

    // one-sector blocks: mapping, bitmap refill, allocation, table bound, free pointer full
    task automatic test_small_block_lookups();
        gap_pct = 15;
        stall_pct = 15;
        apply_setting(5'd9, 11'd16, 32'd1000, 34'd100);
        send_word(KIND_LOAD, 32'd0, 10'd0, 32'd0);
        send_word(KIND_LOAD, 32'd0, 10'd1, UNALLOC);
        send_word(KIND_LOAD, 32'd0, 10'd2, UNALLOC);
        send_word(KIND_LOAD, 32'd0, 10'd3, 32'd50);
        send_word(KIND_READ, 32'd0, 10'd0, 32'd0);
        send_word(KIND_READ, 32'd1, 10'd0, 32'd0);
        send_word(KIND_WRITE, 32'd0, 10'd0, 32'd0);
        send_word(KIND_WRITE, 32'd0, 10'd0, 32'd0);
        send_word(KIND_WRITE, 32'd3, 10'd0, 32'd0);
        send_word(KIND_WRITE, 32'd1, 10'd0, 32'd0);
        send_word(KIND_WRITE, 32'd1, 10'd0, 32'd0);
        send_word(KIND_READ, 32'd20, 10'd0, 32'd0);
        send_word(KIND_WRITE, 32'd20, 10'd0, 32'd0);
        send_word(KIND_SPARE, 32'd3, 10'd0, 32'd0);
        send_word(KIND_LOAD, 32'd0, 10'd1023, 32'hFFFF_FFFE);
        send_word(KIND_WRITE, 32'd2, 10'd0, 32'd0);
        send_word(KIND_READ, SECTOR_MAX, 10'd0, 32'd0);
    endtask

    // largest blocks with an oversized table count, allocation past the disk end
    task automatic test_large_block_allocation();
        apply_setting(5'd31, 11'd2047, 32'd5, 34'd0);
        send_word(KIND_LOAD, 32'hFFFF_FFFF, 10'd0, UNALLOC);
        send_word(KIND_WRITE, 32'd10, 10'd0, 32'd0);
        send_word(KIND_WRITE, 32'd3, 10'd0, 32'd0);
        send_word(KIND_WRITE, 32'd4, 10'd0, 32'd0);
        send_word(KIND_LOAD, 32'd0, 10'd1, 32'h0000_1000);
        send_word(KIND_READ, (32'd1 << 22) + 32'd5, 10'd0, 32'd0);
    endtask

    // block size below the minimum, free pointer at its top and just under the limit
    task automatic test_free_pointer_limit();
        apply_setting(5'd5, 11'd1024, SECTOR_MAX, 34'h3_FFFF_FFFF);
        send_word(KIND_LOAD, 32'd0, 10'd4, UNALLOC);
        send_word(KIND_WRITE, 32'd4, 10'd0, 32'd0);
        settle();
        write_register(REG_FREE_START, 64'h0_FFFF_FFFE);
        send_word(KIND_WRITE, 32'd4, 10'd0, 32'd0);
    endtask

    task automatic test_random_traffic();
        int p;
        for (p = 0; p < 3; p++) begin
            gap_pct = 10 + 10 * p;
            stall_pct = 30 - 10 * p;
            apply_random_setting();
            run_random_items(250, 0);
        end
    endtask

    task automatic test_drain_pause();
        gap_pct = 10;
        stall_pct = 30;
        apply_random_setting();
        run_random_items(200, 40);
    endtask

    task automatic test_back_to_back();
        gap_pct = 0;
        stall_pct = 0;
        apply_random_setting();
        run_random_items(180, 0);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_register_reset();
        test_small_block_lookups();
        test_large_block_allocation();
        test_free_pointer_limit();
        test_random_traffic();
        test_drain_pause();
        test_back_to_back();
        settle();
        repeat (4 * LATENCY) @(posedge i_clk);
        if (error_count == 0 && pending_translations.size() == 0)
            $display("tb_sparse_disk_block_translation_core OK");
        else
            $display("tb_sparse_disk_block_translation_core NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
design/sdbt_pkg.sv
design/sdbt_ram.sv
design/sdbt_front.sv
design/sdbt_back.sv
design/sparse_disk_block_translation_core.sv
sim/tb_sparse_disk_block_translation_core.sv
